[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl core
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, checked out of reset
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the following cycle, checked out of reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// property checked at every edge, reset included
`define ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: reset behavior");

`endif

[rtl/core/mbar_pkg.sv]
// shared types, constants and functions of the modbus ascii to rtu converter
// no dependencies
package mbar_pkg;

    // ascii and frame constants
    localparam logic [7:0]  CHAR_NINE    = 8'h39;
    localparam logic [7:0]  CHAR_ZERO    = 8'h30;
    localparam logic [7:0]  HEX_GAP      = 8'h07;
    localparam logic [7:0]  MIN_DATA_LEN = 8'd7;
    localparam logic [7:0]  LEN_OVERHEAD = 8'd5;

    // crc-16 constants, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // number of output beats one character can cause
    localparam int unsigned BUNDLE_MAX = 3;

    // one output beat
    typedef struct packed {
        logic [7:0] rtu_byte;
        logic       is_crc;
        logic       last;
    } rtu_beat_t;

    // beats produced by one accepted character, in order
    typedef struct packed {
        logic [1:0]                 num;
        rtu_beat_t [BUNDLE_MAX-1:0] beats;
    } beat_bundle_t;

    // hex digit value with the same wrap for invalid characters
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (v > CHAR_NINE) begin
            v = v - HEX_GAP;
        end
        return v - CHAR_ZERO;
    endfunction

    // one byte through the crc register, bit at a time
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // crc byte of the given slot, slot 0 goes out first
    function automatic rtu_beat_t crc_beat(input logic [15:0] crc, input logic high_first,
                                           input logic second);
        rtu_beat_t bt;
        bt.is_crc   = 1'b1;
        bt.last     = second;
        bt.rtu_byte = (high_first ^ second) ? crc[15:8] : crc[7:0];
        return bt;
    endfunction

endpackage

[rtl/core/mbar_frame_dec.sv]
// frame decoder: character position tracking, hex pairing and crc register
// depends on mbar_pkg
module mbar_frame_dec (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            ascii_char,
    input  logic [7:0]            frame_length,
    input  logic                  crc_high_first,
    output mbar_pkg::beat_bundle_t bundle
);
    import mbar_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  high_nib_reg, high_nib_next;
    logic [15:0] crc_reg, crc_next;

    logic [7:0]  ndata;
    logic [8:0]  data_end;
    logic        in_data;
    logic        pair_done;
    logic        is_end;
    logic [7:0]  nib;
    logic [7:0]  byte_val;
    logic [15:0] crc_after;
    rtu_beat_t   data_beat;

    // frame geometry for this character
    always_comb begin
        ndata     = (frame_length >= MIN_DATA_LEN) ? ((frame_length - LEN_OVERHEAD) >> 1) : 8'd0;
        data_end  = {ndata, 1'b0};
        in_data   = (pos_reg != 8'd0) && ({1'b0, pos_reg} <= data_end);
        pair_done = in_data && !pos_reg[0];
        is_end    = ({1'b0, pos_reg} + 9'd1) >= {1'b0, frame_length};
    end

    // byte assembly and crc step
    always_comb begin
        nib                = hex_value(ascii_char);
        byte_val           = {high_nib_reg[3:0], 4'h0} | nib;
        crc_after          = crc_update(crc_reg, byte_val);
        data_beat.rtu_byte = byte_val;
        data_beat.is_crc   = 1'b0;
        data_beat.last     = 1'b0;
    end

    // beats caused by this character
    always_comb begin
        bundle = '0;
        if (pair_done) begin
            bundle.num      = 2'd1;
            bundle.beats[0] = data_beat;
            if ({1'b0, pos_reg} == data_end) begin
                bundle.num      = 2'd3;
                bundle.beats[1] = crc_beat(crc_after, crc_high_first, 1'b0);
                bundle.beats[2] = crc_beat(crc_after, crc_high_first, 1'b1);
            end
        end else if (is_end && (ndata == 8'd0)) begin
            bundle.num      = 2'd2;
            bundle.beats[0] = crc_beat(crc_reg, crc_high_first, 1'b0);
            bundle.beats[1] = crc_beat(crc_reg, crc_high_first, 1'b1);
        end
    end

    // next frame state
    always_comb begin
        pos_next      = pos_reg;
        high_nib_next = high_nib_reg;
        crc_next      = crc_reg;
        if (accept) begin
            if (in_data && pos_reg[0]) begin
                high_nib_next = nib;
            end
            if (pair_done) begin
                crc_next = crc_after;
            end
            if (is_end) begin
                pos_next      = 8'd0;
                high_nib_next = 8'd0;
                crc_next      = CRC_INIT;
            end else begin
                pos_next = pos_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= 8'd0;
            high_nib_reg <= 8'd0;
            crc_reg      <= CRC_INIT;
        end else begin
            pos_reg      <= pos_next;
            high_nib_reg <= high_nib_next;
            crc_reg      <= crc_next;
        end
    end

endmodule

[rtl/core/mbar_beat_queue.sv]
// output queue: takes up to three beats per cycle, hands out one per cycle while out_ready is high
// depends on mbar_pkg
module mbar_beat_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  mbar_pkg::beat_bundle_t bundle,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output mbar_pkg::rtu_beat_t    out_beat
);
    import mbar_pkg::*;

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rtu_beat_t        mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx0, idx1, idx2, idx3;
    logic [1:0]       push_num;
    logic             pop;

    // circular index step
    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] p);
        if (p == IDX_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_comb begin
        idx0     = wr_ptr_reg;
        idx1     = step_idx(idx0);
        idx2     = step_idx(idx1);
        idx3     = step_idx(idx2);
        push_num = push ? bundle.num : 2'd0;
        pop      = out_valid && out_ready;
    end

    // read side
    assign out_valid = (count_reg != '0);
    assign out_beat  = mem_reg[rd_ptr_reg];
    assign room      = (count_reg <= CNT_W'(DEPTH - BUNDLE_MAX));

    // pointer and fill bookkeeping
    always_comb begin
        case (push_num)
            2'd0:    wr_ptr_next = idx0;
            2'd1:    wr_ptr_next = idx1;
            2'd2:    wr_ptr_next = idx2;
            default: wr_ptr_next = idx3;
        endcase
        rd_ptr_next = pop ? step_idx(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_num) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // beat storage, no reset
    always_ff @(posedge aclk) begin
        if (push_num >= 2'd1) begin
            mem_reg[idx0] <= bundle.beats[0];
        end
        if (push_num >= 2'd2) begin
            mem_reg[idx1] <= bundle.beats[1];
        end
        if (push_num == 2'd3) begin
            mem_reg[idx2] <= bundle.beats[2];
        end
    end

endmodule

[rtl/core/modbus_ascii_to_rtu_with_crc_top.sv]
// top level of the modbus ascii to rtu converter with appended crc-16
// depends on mbar_pkg, mbar_frame_dec, mbar_beat_queue and assert_macros.svh
//
// usage:
//   s_ channel: one ascii character per beat, with the total character count
//   of its frame. the start mark, the lrc pair, cr and lf produce no output.
//   m_ channel: one rtu byte per beat. each completed hex pair gives a data
//   byte; after the last data byte come two crc bytes (is_crc high), the
//   second with last high. frames under seven characters give only the crc
//   of empty data, on their final character.
//   cfg channel: one bit, crc_high_first (1 after reset): 1 sends the crc
//   register's high byte first, 0 the low byte first. cfg_ready is always high.
// timing and throughput:
//   a byte is registered in the output queue when its character is accepted and presented on m_ from there.
//   one character is taken per cycle while the output queue has room for
//   three beats; with the default depth of four and a receiver that drains
//   every cycle the input never stalls except for the crc pair of a frame.
// reset: frame position, crc register and output queue clear at once; the
//   configuration bit returns to high-first.
// stall: a stalled receiver fills the output queue, then s_ready drops
//   until beats drain; nothing is dropped.
module modbus_ascii_to_rtu_with_crc_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    // character input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ascii_char,
    input  logic [7:0] s_frame_length,
    // rtu byte output
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_rtu_byte,
    output logic       m_is_crc,
    output logic       m_last,
    // configuration write
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import mbar_pkg::*;

`include "assert_macros.svh"

    logic         crc_high_first_reg, crc_high_first_next;
    logic         accept;
    logic         room;
    beat_bundle_t bundle;
    rtu_beat_t    out_beat;

    // configuration register
    assign cfg_ready           = 1'b1;
    assign crc_high_first_next = (cfg_valid && cfg_ready) ? cfg_data : crc_high_first_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_high_first_reg <= 1'b1;
        end else begin
            crc_high_first_reg <= crc_high_first_next;
        end
    end

    // input handshake
    assign s_ready = room;
    assign accept  = s_valid && s_ready;

    mbar_frame_dec u_frame_dec (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .ascii_char     (s_ascii_char),
        .frame_length   (s_frame_length),
        .crc_high_first (crc_high_first_reg),
        .bundle         (bundle)
    );

    mbar_beat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_beat_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .bundle    (bundle),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_beat  (out_beat)
    );

    // output fields
    assign m_rtu_byte = out_beat.rtu_byte;
    assign m_is_crc   = out_beat.is_crc;
    assign m_last     = out_beat.last;

    // the frame's final byte is always a crc byte
    `ASSERT_SAME(a_last_is_crc, aclk, aresetn, m_valid && m_last, m_is_crc)

    // the first crc byte is followed directly by the second
    `ASSERT_NEXT(a_crc_pair, aclk, aresetn, m_valid && m_ready && m_is_crc && !m_last,
                 m_valid && m_is_crc && m_last)

    // queue is empty right after reset
    `ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_valid)

endmodule
